### hw/rtl/mai_pkg.sv
// Package for the multi-axis motion integrator.
// Holds axis count, request codes, sequencer states and the clamp helper.
// No dependencies.
package mai_pkg;

  localparam int AXIS_COUNT = 4;
  localparam int AXIS_W     = 2;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_SET  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam int POS_W  = 24;
  localparam int VEL_W  = 25;
  localparam int CMD_W  = 32;
  localparam int OPB_W  = 17;
  localparam int PROD_W = VEL_W + OPB_W;
  localparam int SUM_W  = 36;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_DAMP,
    ST_ACC,
    ST_MUL_A,
    ST_VEL,
    ST_MUL_V,
    ST_POS,
    ST_RESP
  } state_t;

  // Symmetric clamp of a wide signed value to +-lim.
  function automatic logic signed [VEL_W-1:0] clamp_sym(
    input logic signed [SUM_W-1:0] x,
    input logic [POS_W-1:0]        lim
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] r;
    hi = $signed({{(SUM_W-POS_W){1'b0}}, lim});
    lo = -hi;
    if (x > hi) begin
      r = hi;
    end else if (x < lo) begin
      r = lo;
    end else begin
      r = x;
    end
    return r[VEL_W-1:0];
  endfunction

endpackage

### hw/rtl/mai_mul_unit.sv
// Shared signed multiplier with a registered product.
// Depends on mai_pkg for operand widths.
module mai_mul_unit import mai_pkg::*; (
  input  logic                     clk,
  input  logic signed [VEL_W-1:0]  op_a,
  input  logic signed [OPB_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a * op_b);
  end

  assign prod = prod_r;

endmodule

### hw/rtl/multi_axis_motion_integrator.sv
// Multi-axis motion integrator, top level.
// A read or index error result goes via the response state to the output
// register once it is free. A tick with nonzero dt steps each axis through
// MUL_DAMP, ACC, MUL_A, VEL, MUL_V and POS on the shared multiplier. Valid sets,
// ignored requests and zero-dt ticks stay idle. A new request is accepted only idle.
// Synchronous active-low reset clears axis and limit registers, but sets min switches.
module multi_axis_motion_integrator import mai_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: axis_index[1:0], accel_value[33:2], time_step[49:34], zero pad
  input  logic [55:0] in_tdata,
  // in_tuser: req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: position_out[23:0], velocity_out[48:24],
  // commanded_accel_out[80:49], min_switch[81], max_switch[82], zero pad
  output logic [87:0] out_tdata,
  // out_tuser: index_error[0]
  output logic [0:0]  out_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [63:0]              lim_r [AXIS_COUNT];
  logic [POS_W-1:0]         pos_r [AXIS_COUNT];
  logic signed [VEL_W-1:0]  vel_r [AXIS_COUNT];
  logic signed [CMD_W-1:0]  cmd_r [AXIS_COUNT];
  logic [AXIS_COUNT-1:0]    lsw_r;
  logic [AXIS_COUNT-1:0]    hsw_r;

  logic [AXIS_W-1:0]        cur_r, cur_nxt;
  logic [15:0]              dt_r;
  logic                     err_r;
  logic signed [VEL_W-1:0]  a_r, a_nxt;
  logic signed [VEL_W-1:0]  v_r, v_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [87:0]              out_data_r;
  logic                     out_err_r;

  logic [1:0]               in_req;
  logic [AXIS_W-1:0]        in_idx;
  logic signed [CMD_W-1:0]  in_accel;
  logic [15:0]              in_dt;
  logic                     accept;
  logic                     in_idx_bad;
  logic                     set_en;
  logic                     wb_en;
  logic                     out_load;

  logic [POS_W-1:0]         len;
  logic [POS_W-1:0]         smax;
  logic [POS_W-1:0]         amax;
  logic [15:0]              damp;

  logic signed [VEL_W-1:0]  mul_a;
  logic signed [OPB_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  logic signed [SUM_W-1:0]  damp_term;
  logic signed [SUM_W-1:0]  vel_sum;
  logic signed [POS_W+2:0]  pos_sum;
  logic                     hit_lo;
  logic                     hit_hi;
  logic [POS_W-1:0]         p_new;
  logic signed [VEL_W-1:0]  v_wb;

  assign in_req   = in_tuser;
  assign in_idx   = in_tdata[1:0];
  assign in_accel = $signed(in_tdata[33:2]);
  assign in_dt    = in_tdata[49:34];

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign in_idx_bad = ({1'b0, in_idx} >= (AXIS_W+1)'(AXIS_COUNT));
  assign set_en     = accept && (in_req == REQ_SET) && !in_idx_bad;
  assign wb_en      = (state_r == ST_POS);
  assign out_load   = (state_r == ST_RESP) && (!out_valid_r || out_tready);

  assign len  = {lim_r[cur_r][15:0], 8'h00};
  assign smax = {lim_r[cur_r][31:16], 8'h00};
  assign amax = {lim_r[cur_r][47:32], 8'h00};
  assign damp = lim_r[cur_r][63:48];

  mai_mul_unit u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req == REQ_TICK) begin
            if (in_dt != 16'd0) begin
              state_nxt = ST_MUL_DAMP;
            end
          end else if (in_req == REQ_READ || (in_req == REQ_SET && in_idx_bad)) begin
            state_nxt = ST_RESP;
          end
        end
      end
      ST_MUL_DAMP: state_nxt = ST_ACC;
      ST_ACC:      state_nxt = ST_MUL_A;
      ST_MUL_A:    state_nxt = ST_VEL;
      ST_VEL:      state_nxt = ST_MUL_V;
      ST_MUL_V:    state_nxt = ST_POS;
      ST_POS: begin
        if (cur_r == AXIS_W'(AXIS_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_MUL_DAMP;
        end
      end
      ST_RESP: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath arithmetic; the product register always holds the previous step's multiply.
  assign damp_term = {{2{prod[PROD_W-1]}}, prod[PROD_W-1:8]};
  assign vel_sum   = {{(SUM_W-VEL_W){vel_r[cur_r][VEL_W-1]}}, vel_r[cur_r]}
                   + {{(SUM_W-(PROD_W-16)){prod[PROD_W-1]}}, prod[PROD_W-1:16]};
  assign pos_sum   = $signed({3'b000, pos_r[cur_r]}) + $signed({prod[PROD_W-1], prod[PROD_W-1:16]});
  assign hit_lo    = (pos_sum <= 0);
  assign hit_hi    = !hit_lo && (pos_sum >= $signed({3'b000, len}));
  assign p_new     = hit_lo ? '0 : (hit_hi ? len : pos_sum[POS_W-1:0]);
  assign v_wb      = (hit_lo || hit_hi) ? '0 : v_r;

  // Step outputs: multiplier operands and working register updates.
  always_comb begin
    mul_a         = v_r;
    mul_b         = {1'b0, dt_r};
    a_nxt         = a_r;
    v_nxt         = v_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cur_nxt = (in_req == REQ_TICK) ? '0 : in_idx;
        end
      end
      ST_MUL_DAMP: begin
        mul_a = vel_r[cur_r];
        mul_b = {1'b0, damp};
        a_nxt = clamp_sym(SUM_W'(cmd_r[cur_r]), amax);
      end
      ST_ACC: begin
        // Damping acts only when the stored command is exactly zero.
        if (cmd_r[cur_r] == '0) begin
          a_nxt = clamp_sym(-damp_term, amax);
        end
      end
      ST_MUL_A: begin
        mul_a = a_r;
      end
      ST_VEL: begin
        v_nxt = clamp_sym(vel_sum, smax);
      end
      ST_MUL_V: begin
        mul_a = v_r;
      end
      ST_POS: begin
        cur_nxt = cur_r + AXIS_W'(1);
      end
      ST_RESP: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      lsw_r       <= '1;
      hsw_r       <= '0;
      for (int i = 0; i < AXIS_COUNT; i++) begin
        lim_r[i] <= '0;
        pos_r[i] <= '0;
        vel_r[i] <= '0;
        cmd_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && ({1'b0, cfg_index} < (AXIS_W+1)'(AXIS_COUNT))) begin
        lim_r[cfg_index[AXIS_W-1:0]] <= cfg_wdata;
      end
      if (set_en) begin
        cmd_r[in_idx] <= in_accel;
      end
      if (wb_en) begin
        pos_r[cur_r] <= p_new;
        vel_r[cur_r] <= v_wb;
        lsw_r[cur_r] <= (p_new == '0);
        hsw_r[cur_r] <= (p_new >= len);
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    a_r   <= a_nxt;
    v_r   <= v_nxt;
    if (accept) begin
      dt_r  <= in_dt;
      err_r <= in_idx_bad;
    end
    if (out_load) begin
      out_err_r <= err_r;
      if (err_r) begin
        out_data_r <= '0;
      end else begin
        out_data_r <= {5'b00000, hsw_r[cur_r], lsw_r[cur_r], cmd_r[cur_r],
                       vel_r[cur_r], pos_r[cur_r]};
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_err_r;

endmodule
